[hw/rtl/wpm_pkg.sv]
// ----------------------------------------------------------------------------
// Wildcard pattern match package
// Command codes, pattern wildcard bytes and the structs that pass control
// and status between the top level and the match core.
// ----------------------------------------------------------------------------
package wpm_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_REPORT = 2'd3
    } cmd_t;

    // Pattern byte that matches any run of text bytes, the empty run included.
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    // Pattern byte that matches exactly one text byte of any value.
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    typedef struct packed {
        logic       en;
        cmd_t       cmd;
        logic [7:0] char_value;
    } step_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } result_t;

endpackage

[hw/rtl/wpm_if.sv]
// ----------------------------------------------------------------------------
// Wildcard pattern match channels
// Valid/ready channels for command requests and for match reports.
// ----------------------------------------------------------------------------
interface wpm_in_if;
    logic            valid;
    logic            ready;
    wpm_pkg::cmd_t   cmd;
    logic [7:0]      char_value;

    modport source (output valid, output cmd, output char_value, input ready);
    modport sink   (input valid, input cmd, input char_value, output ready);
endinterface

interface wpm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

[hw/rtl/wpm_scan.sv]
// ----------------------------------------------------------------------------
// Wildcard pattern match prefix scan
// Log-depth generate/propagate scan: carry[i] = gen[i] | prop[i] & carry[i-1],
// with nothing coming in below bit zero.
// ----------------------------------------------------------------------------
module wpm_scan #(
    parameter int WIDTH = 33
) (
    input  logic [WIDTH-1:0] gen,
    input  logic [WIDTH-1:0] prop,
    output logic [WIDTH-1:0] carry
);

    localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [LEVELS:0][WIDTH-1:0] g_lvl;
    logic [LEVELS:0][WIDTH-1:0] p_lvl;

    assign g_lvl[0] = gen;
    assign p_lvl[0] = prop;

    for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
        localparam int DIST = 1 << lv;
        for (genvar b = 0; b < WIDTH; b++) begin : g_bit
            if (b >= DIST) begin : g_merge
                assign g_lvl[lv+1][b] = g_lvl[lv][b] | (p_lvl[lv][b] & g_lvl[lv][b-DIST]);
                assign p_lvl[lv+1][b] = p_lvl[lv][b] & p_lvl[lv][b-DIST];
            end else begin : g_pass
                assign g_lvl[lv+1][b] = g_lvl[lv][b];
                assign p_lvl[lv+1][b] = p_lvl[lv][b];
            end
        end
    end

    assign carry = g_lvl[LEVELS];

endmodule

[hw/rtl/wpm_core.sv]
// ----------------------------------------------------------------------------
// Wildcard pattern match core
// Holds the pattern bytes, the pattern length, the overflow flag and the
// match column, and applies one command per enabled cycle.
// ----------------------------------------------------------------------------
module wpm_core #(
    parameter int MAX_PATTERN = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  wpm_pkg::step_t   step,
    output wpm_pkg::result_t status
);

    import wpm_pkg::*;

    localparam int COL_W = MAX_PATTERN + 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    logic [MAX_PATTERN-1:0][7:0] store_reg;
    logic [LEN_W-1:0]            len_reg;
    logic [LEN_W-1:0]            len_next;
    logic                        ovf_reg;
    logic                        ovf_next;
    logic [COL_W-1:0]            col_reg;
    logic [COL_W-1:0]            col_next;

    logic                        append_ok;
    logic [MAX_PATTERN-1:0]      is_star;
    logic [MAX_PATTERN-1:0]      is_hit;
    logic [MAX_PATTERN-1:0]      star_eff;
    logic [COL_W-1:0]            g_text;
    logic [COL_W-1:0]            p_text;
    logic [COL_W-1:0]            g_empty;
    logic [COL_W-1:0]            p_empty;
    logic [COL_W-1:0]            col_text;
    logic [COL_W-1:0]            col_empty;

    assign append_ok = step.en && (step.cmd == CMD_APPEND) && (len_reg < MAX_LEN);

    // Pattern bytes; each position is read only by its own column cell.
    always_ff @(posedge clk)
    begin
        if (append_ok)
        begin
            store_reg[len_reg[IDX_W-1:0]] <= step.char_value;
        end
    end

    // Per-position compare. The star flags seen by the empty column already
    // include a byte that is being appended in this cycle.
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            is_star[i]  = (store_reg[i] == STAR_BYTE);
            is_hit[i]   = (store_reg[i] == ANY_BYTE) || (store_reg[i] == step.char_value);
            star_eff[i] = (append_ok && (len_reg[IDX_W-1:0] == IDX_W'(i)))
                          ? (step.char_value == STAR_BYTE) : is_star[i];
        end
    end

    // A star cell keeps a match from the left or from the previous column and
    // passes a match up through a run of stars; other cells only move
    // diagonally.
    always_comb
    begin
        g_text     = '0;
        p_text     = '0;
        g_empty    = '0;
        p_empty    = '0;
        g_empty[0] = 1'b1;
        for (int i = 1; i < COL_W; i++)
        begin
            p_empty[i] = star_eff[i-1];
            p_text[i]  = is_star[i-1];
            g_text[i]  = is_star[i-1] ? (col_reg[i-1] | col_reg[i])
                                      : (is_hit[i-1] & col_reg[i-1]);
        end
    end

    wpm_scan #(.WIDTH(COL_W)) u_scan_text (
        .gen   (g_text),
        .prop  (p_text),
        .carry (col_text)
    );

    wpm_scan #(.WIDTH(COL_W)) u_scan_empty (
        .gen   (g_empty),
        .prop  (p_empty),
        .carry (col_empty)
    );

    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        col_next = col_reg;
        if (step.en)
        begin
            unique case (step.cmd)
                CMD_CLEAR:
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                    col_next = col_empty;
                end
                CMD_APPEND:
                begin
                    if (append_ok)
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    col_next = col_empty;
                end
                CMD_TEXT:
                begin
                    col_next = col_text;
                end
                CMD_REPORT:
                begin
                    col_next = col_empty;
                end
                default:
                begin
                    col_next = col_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
            col_reg <= COL_W'(1);
        end
        else
        begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
            col_reg <= col_next;
        end
    end

    assign status.matched          = !ovf_reg && col_reg[len_reg];
    assign status.pattern_overflow = ovf_reg;

endmodule

[hw/rtl/wildcard_pattern_match.sv]
// ----------------------------------------------------------------------------
// Wildcard pattern match
// Streaming matcher of a whole text against a pattern with '*' and '?'.
// ----------------------------------------------------------------------------
// The block takes one command request per clock cycle, back to back, while
// no report is held in its input register, and returns one result for each
// end-of-text request. A request first lands in an input register; from
// there the match core applies it to the pattern store and the match
// column, and an end-of-text request writes its report into the output
// register. The column update for a text byte is a
// compare in every pattern position followed by a log-depth prefix scan over
// MAX_PATTERN + 1 positions, so the scan depth grows with log2(MAX_PATTERN).
// Clear, append and text requests give no result and keep flowing while a
// report waits in the output register; only a second report stalls in the
// input register until the first one is taken. Pattern bytes beyond
// MAX_PATTERN are dropped and flag an overflow, after which every report
// says no match until the next clear. Editing the pattern, or a report,
// starts a new empty text.
// ----------------------------------------------------------------------------
module wildcard_pattern_match #(
    parameter int MAX_PATTERN = 32
) (
    input logic         clk,
    input logic         rst_n,
    wpm_in_if.sink      item,
    wpm_out_if.source   result
);

    import wpm_pkg::*;

    // Input register stage.
    logic       s1_valid_reg;
    logic       s1_valid_next;
    cmd_t       s1_cmd_reg;
    logic [7:0] s1_char_reg;

    // Output register stage.
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_data_reg;

    logic       s1_is_report;
    logic       out_free;
    logic       s1_fire;
    logic       in_fire;
    step_t      step;
    result_t    status;

    // A report may leave the input register only when the output register
    // is empty or is being emptied in this cycle.
    assign s1_is_report = (s1_cmd_reg == CMD_REPORT);
    assign out_free     = !out_valid_reg || result.ready;
    assign s1_fire      = s1_valid_reg && (!s1_is_report || out_free);
    assign item.ready   = !s1_valid_reg || s1_fire;
    assign in_fire      = item.valid && item.ready;

    assign step.en         = s1_fire;
    assign step.cmd        = s1_cmd_reg;
    assign step.char_value = s1_char_reg;

    wpm_core #(.MAX_PATTERN(MAX_PATTERN)) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .status (status)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_is_report)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg  <= item.cmd;
            s1_char_reg <= item.char_value;
        end
        if (s1_fire && s1_is_report)
        begin
            out_data_reg <= status;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.matched          = out_data_reg.matched;
    assign result.pattern_overflow = out_data_reg.pattern_overflow;

`ifndef SYNTH
    // A new result only ever comes from a report request that left the
    // input register in the cycle before.
    a_result_from_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_cmd_reg == CMD_REPORT))
        else $error("result raised without a report request");

    // An overflowed pattern never reports a match.
    a_no_match_on_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.matched && out_data_reg.pattern_overflow))
        else $error("match reported for an overflowed pattern");

    // A request held in the input register is neither lost nor overwritten.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_cmd_reg)
                                       && $stable(s1_char_reg)))
        else $error("stalled request lost in the input register");
`endif

endmodule

[tb/wildcard_pattern_match_tb.sv]
// ----------------------------------------------------------------------------
// Wildcard pattern match testbench
// Drives clear, append, text and end-of-text requests into the matcher and
// checks every match report against a cycle-free predictor of the match
// column, under random idling on both channels and a long receiver stall.
// ----------------------------------------------------------------------------
module wildcard_pattern_match_tb;

    import wpm_pkg::*;

    localparam int MAX_PAT      = 32;
    localparam int TARGET_REQS  = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // Predicts the report of every end-of-text request and compares it with
    // what the block returns. The pattern, the match column and the overflow
    // flag mirror the block's own state.
    class match_scoreboard;
        logic [7:0]     pat_bytes [MAX_PAT];
        int unsigned    pat_len;
        bit [MAX_PAT:0] column;
        bit             overflow;
        result_t        pending_reports [$];
        int unsigned    mismatches;
        int unsigned    requests;
        int unsigned    reports;
        int unsigned    hits;
        int unsigned    overflow_reports;

        function new();
            pat_len  = 0;
            overflow = 1'b0;
            restart_text();
        endfunction

        // Column of the empty text: bit 0, then a run of leading stars.
        function void restart_text();
            column    = '0;
            column[0] = 1'b1;
            for (int i = 1; i <= pat_len; i++)
                column[i] = column[i-1] && (pat_bytes[i-1] == STAR_BYTE);
        endfunction

        // A star always takes the star rule, even for a star in the text.
        function void advance_text(logic [7:0] ch);
            bit [MAX_PAT:0] nxt;
            nxt = '0;
            for (int i = 1; i <= pat_len; i++)
            begin
                if (pat_bytes[i-1] == STAR_BYTE)
                    nxt[i] = column[i-1] || column[i] || nxt[i-1];
                else if (pat_bytes[i-1] == ANY_BYTE || pat_bytes[i-1] == ch)
                    nxt[i] = column[i-1];
            end
            column = nxt;
        endfunction

        function void note_request(cmd_t cmd, logic [7:0] ch);
            result_t exp_rpt;
            requests++;
            case (cmd)
                CMD_CLEAR:
                begin
                    pat_len  = 0;
                    overflow = 1'b0;
                    restart_text();
                end
                CMD_APPEND:
                begin
                    if (pat_len < MAX_PAT)
                    begin
                        pat_bytes[pat_len] = ch;
                        pat_len++;
                    end
                    else
                        overflow = 1'b1;
                    restart_text();
                end
                CMD_TEXT:
                    advance_text(ch);
                CMD_REPORT:
                begin
                    exp_rpt.matched          = !overflow && column[pat_len];
                    exp_rpt.pattern_overflow = overflow;
                    pending_reports.push_back(exp_rpt);
                    restart_text();
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] ERROR: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic matched, logic pattern_overflow);
            result_t exp_rpt;
            if (pending_reports.size() == 0)
            begin
                report("match report arrived with none outstanding");
                return;
            end
            exp_rpt = pending_reports.pop_front();
            reports++;
            if (exp_rpt.matched)
                hits++;
            if (exp_rpt.pattern_overflow)
                overflow_reports++;
            if (matched !== exp_rpt.matched)
                report($sformatf("report %0d: matched %b, expected %b",
                                 reports, matched, exp_rpt.matched));
            if (pattern_overflow !== exp_rpt.pattern_overflow)
                report($sformatf("report %0d: pattern_overflow %b, expected %b",
                                 reports, pattern_overflow, exp_rpt.pattern_overflow));
        endtask
    endclass

    logic clk;
    logic rst_n;

    wpm_in_if  req_ch ();
    wpm_out_if rpt_ch ();

    wildcard_pattern_match #(
        .MAX_PATTERN (MAX_PAT)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (req_ch),
        .result (rpt_ch)
    );

    match_scoreboard sb;

    // Idle rates of the two channels, in percent; changed between phases.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // The sender asks for a long receiver stall by bumping hold_asks; the
    // receiver counts the stall out in its own process.
    int unsigned hold_asks;
    int unsigned holds_served;
    int unsigned hold_left;

    int unsigned cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: a hang anywhere in the handshakes ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d reports outstanding.",
                     cycle_count, sb.pending_reports.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side. Values are sampled at the clock edge, before the block's
    // own registers update, and ready for the next cycle is chosen in the
    // same step with a single nonblocking assignment.
    always @(posedge clk)
    begin
        if (rst_n && rpt_ch.valid && rpt_ch.ready)
            sb.check_result(rpt_ch.matched, rpt_ch.pattern_overflow);
        if (holds_served != hold_asks)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rpt_ch.ready <= 1'b0;
        end
        else
            rpt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one request and returns at the edge where it is accepted. When
    // the sender idles, valid drops in this step and rises again only at a
    // later edge, so valid never gets two assignments in one step.
    task automatic send_request(cmd_t cmd, logic [7:0] ch);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= cmd;
        req_ch.char_value <= ch;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(cmd, ch);
    endtask

    // Pauses the sender until every outstanding report has been returned.
    task automatic wait_reports_drained();
        req_ch.valid <= 1'b0;
        while (sb.pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // Pattern bytes lean on a small alphabet and the two wildcards so that
    // texts match often; some bytes are fully random.
    function automatic logic [7:0] pick_pattern_byte();
        case ($urandom_range(9))
            0, 1, 2: return 8'h61;
            3:       return 8'h62;
            4, 5:    return STAR_BYTE;
            6:       return ANY_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_filler_byte();
        case ($urandom_range(3))
            0:       return 8'h61;
            1:       return 8'h62;
            2:       return STAR_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One well-formed sequence: a fresh pattern, then a few texts built from
    // it (a star expands to a short run, a '?' to any byte), some of them
    // corrupted, each closed by an end-of-text request. About one pattern in
    // ten is sized near the store and mostly runs past it, for the overflow flag.
    task automatic run_pattern_sequence();
        logic [7:0]  pat_q [$];
        logic [7:0]  txt_q [$];
        int unsigned n_pat;
        int unsigned n_texts;
        int unsigned run_len;
        logic [7:0]  b;

        send_request(CMD_CLEAR, 8'($urandom_range(255)));
        n_pat = ($urandom_range(9) == 0) ? $urandom_range(MAX_PAT - 2, MAX_PAT + 4)
                                         : $urandom_range(0, 8);
        for (int i = 0; i < n_pat; i++)
        begin
            b = pick_pattern_byte();
            pat_q.push_back(b);
            send_request(CMD_APPEND, b);
        end

        n_texts = $urandom_range(1, 4);
        for (int t = 0; t < n_texts; t++)
        begin
            txt_q.delete();
            foreach (pat_q[i])
            begin
                if (txt_q.size() >= 40)
                    break;
                if (pat_q[i] == STAR_BYTE)
                begin
                    run_len = $urandom_range(0, 3);
                    repeat (run_len)
                        txt_q.push_back(pick_filler_byte());
                end
                else if (pat_q[i] == ANY_BYTE)
                    txt_q.push_back(pick_filler_byte());
                else
                    txt_q.push_back(pat_q[i]);
            end
            // Corrupt a third of the texts: flip a byte, add or drop one.
            case ($urandom_range(11))
                0, 1:
                    if (txt_q.size() > 0)
                        txt_q[$urandom_range(txt_q.size() - 1)] = 8'($urandom_range(255));
                2:
                    txt_q.push_back(pick_filler_byte());
                3:
                    if (txt_q.size() > 0)
                        void'(txt_q.pop_back());
                default:
                    ;
            endcase
            foreach (txt_q[i])
                send_request(CMD_TEXT, txt_q[i]);
            send_request(CMD_REPORT, 8'($urandom_range(255)));
        end
    endtask

    // A few requests of any kind and any byte, including pattern edits in
    // the middle of a text and reports right after a clear.
    task automatic run_noise();
        int unsigned n;
        n = $urandom_range(1, 5);
        repeat (n)
            send_request(cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    // The receiver stalls for a long stretch while the sender keeps pushing
    // reports back to back, so the output register fills, the second report
    // backs up in the input register, and the input stalls too.
    task automatic run_backpressure_burst();
        hold_asks++;
        send_request(CMD_CLEAR, 8'h00);
        send_request(CMD_APPEND, STAR_BYTE);
        send_request(CMD_APPEND, ANY_BYTE);
        for (int i = 0; i < 12; i++)
        begin
            if (i[0])
                send_request(CMD_TEXT, 8'($urandom_range(255)));
            send_request(CMD_REPORT, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        int unsigned phase_reqs;

        sb                = new();
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_CLEAR;
        req_ch.char_value = 8'h00;
        rpt_ch.ready      = 1'b0;
        send_idle_pct     = 29;
        recv_stall_pct    = 80;
        hold_asks         = 0;
        holds_served      = 0;
        hold_left         = 0;
        cycle_count       = 0;

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Empty pattern against empty and non-empty text.
        send_request(CMD_REPORT, 8'h00);
        send_request(CMD_TEXT, 8'hFF);
        send_request(CMD_REPORT, 8'hFF);
        // A lone star matches the empty text and a star in the text.
        send_request(CMD_APPEND, STAR_BYTE);
        send_request(CMD_REPORT, 8'h00);
        send_request(CMD_TEXT, STAR_BYTE);
        send_request(CMD_REPORT, 8'h55);
        // Star followed by a literal zero byte.
        send_request(CMD_APPEND, 8'h00);
        send_request(CMD_TEXT, 8'hAA);
        send_request(CMD_TEXT, 8'h00);
        send_request(CMD_REPORT, 8'hAA);
        // '?' then 0xFF: matches any byte followed by 0xFF.
        send_request(CMD_CLEAR, 8'hFF);
        send_request(CMD_APPEND, ANY_BYTE);
        send_request(CMD_APPEND, 8'hFF);
        send_request(CMD_TEXT, 8'h41);
        send_request(CMD_TEXT, 8'hFF);
        send_request(CMD_REPORT, 8'h00);
        // An append in the middle of a text restarts that text.
        send_request(CMD_TEXT, 8'h41);
        send_request(CMD_APPEND, STAR_BYTE);
        send_request(CMD_TEXT, 8'hFF);
        send_request(CMD_REPORT, 8'h00);
        // A byte that the '?' matches, then a clear with a text half-way through.
        send_request(CMD_TEXT, 8'h3E);
        send_request(CMD_CLEAR, 8'h7F);
        send_request(CMD_REPORT, 8'h80);
        wait_reports_drained();

        // Random part in three idle phases: slow receiver, slow sender, and
        // full speed. The sender pauses at each phase change until every
        // report is back.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 80;
                end
                1:
                begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 29;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    run_backpressure_burst();
                end
            endcase
            phase_reqs = (TARGET_REQS * (phase + 1)) / 3;
            while (sb.requests < phase_reqs)
            begin
                if ($urandom_range(9) == 0)
                    run_noise();
                run_pattern_sequence();
            end
            wait_reports_drained();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.pending_reports.size() != 0)
            sb.report($sformatf("%0d reports never returned",
                                sb.pending_reports.size()));

        $display("Run covered %0d requests and %0d reports: %0d matches, %0d overflowed.",
                 sb.requests, sb.reports, sb.hits, sb.overflow_reports);
        $display("Idle phases on both channels plus a %0d-cycle receiver stall; %0d cycles.",
                 HOLD_CYCLES, cycle_count);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/wpm_pkg.sv
hw/rtl/wpm_if.sv
hw/rtl/wpm_scan.sv
hw/rtl/wpm_core.sv
hw/rtl/wildcard_pattern_match.sv
tb/wildcard_pattern_match_tb.sv
